/* hw/rtl/rcbs_pkg.sv */
// Package for the radio clock button sequencer.
// Phase, event and register index codes shared by the top level and its checker.
// No dependencies.
package rcbs_pkg;

   // Sequencer phases, numbered as they are reported on the result channel
   typedef enum logic [3:0] {
      PH_POWER_OFF      = 4'd0,
      PH_POWER_ON_WAIT  = 4'd1,
      PH_POWER_ON       = 4'd2,
      PH_PRESS_RC_OFF   = 4'd3,
      PH_RELEASE_RC_OFF = 4'd4,
      PH_RC_OFF         = 4'd5,
      PH_PRESS_FORMAT   = 4'd6,
      PH_RELEASE_FORMAT = 4'd7,
      PH_PRESS_RC_ON    = 4'd8,
      PH_RELEASE_RC_ON  = 4'd9,
      PH_RC_ON          = 4'd10,
      PH_RUNNING        = 4'd11
   } phase_type;

   // Event reported with each result
   typedef enum logic [1:0] {
      EV_NONE    = 2'd0,
      EV_READY   = 2'd1,
      EV_RECOVER = 2'd2,
      EV_STOPPED = 2'd3
   } event_type;

   // Configuration register indexes (byte address = 4 * index)
   typedef enum logic [2:0] {
      REG_POWER_WAIT = 3'd0,
      REG_PRESS      = 3'd1,
      REG_RELEASE    = 3'd2,
      REG_RETRY      = 3'd3,
      REG_IDLE       = 3'd4,
      REG_FAIL_MIN   = 3'd5,
      REG_FAIL_MAX   = 3'd6
   } reg_type;

   // Input transaction kinds carried on tuser
   localparam logic CMD_TICK     = 1'b0;
   localparam logic CMD_POWER_ON = 1'b1;

   // Result word layout
   localparam int unsigned RESULT_BITS = 10;
   localparam int unsigned RSP_TDATA_BITS = 16;
   localparam int unsigned CSR_ADDR_BITS = 5;

endpackage

/* hw/rtl/radio_clock_button_sequencer_unit.sv */
// Radio clock button sequencer top level: phase machine, button timer,
// line change timer, APB register file and a two-entry result queue.
// Depends on rcbs_pkg.
//
//   channel   direction  transaction                         handshake
//   req_      in         tuser command, tdata request level  tvalid/tready
//   rsp_      out        tdata phase, buttons, event          tvalid/tready
//   csr_      in/out     APB register write/read              psel/penable, pready=1
//
// One transaction enters per cycle while req_tready is high; its result is queued.
// All state is updated at acceptance by a single pass of logic (counter
// increment, countdown decrement, window compare, phase update).
// Results queue in two entries; req_tready drops only while both are full.
// Reset is synchronous and returns every register but the queue storage to its default.
module radio_clock_button_sequencer_unit #(
   parameter int unsigned TICK_COUNTER_BITS = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request stream
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [7:0]                           req_tdata,  // [0] request_line
   input  logic                                 req_tuser,  // [0] command
   // result stream
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [0] power_drive, [1] radio_button_press, [2] format_button_press,
   // [6:3] phase, [7] signal_requested, [9:8] event_code
   output logic [rcbs_pkg::RSP_TDATA_BITS-1:0]  rsp_tdata,
   // configuration
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [rcbs_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [31:0]                          csr_pwdata,
   output logic [31:0]                          csr_prdata,
   output logic                                 csr_pready
);
   import rcbs_pkg::*;

   localparam int unsigned CmpBits = (TICK_COUNTER_BITS > 32) ? TICK_COUNTER_BITS : 32;
   localparam logic [TICK_COUNTER_BITS-1:0] SinceMax = {TICK_COUNTER_BITS{1'b1}};

   // configuration registers
   logic [31:0] power_wait_ff, press_ff, release_ff, retry_ff, idle_ff;
   logic [31:0] fail_min_ff, fail_max_ff;
   logic        csr_write;

   // sequencer state
   phase_type                     phase_ff, phase_in;
   logic [31:0]                   countdown_ff, countdown_in;
   logic                          running_ff, running_in;
   logic                          armed_ff, armed_in;
   logic                          last_level_ff, last_level_in;
   logic                          requested_ff, requested_in;
   logic [TICK_COUNTER_BITS-1:0]  since_ff, since_in;
   event_type                     event_in;

   // result queue
   logic [RESULT_BITS-1:0] queue_ff [2];
   logic                   wr_ptr_ff, rd_ptr_ff;
   logic [1:0]             count_ff;
   logic [RESULT_BITS-1:0] result_word;
   logic                   req_accept, rsp_accept;

   logic                   req_line;

   // register file
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         power_wait_ff <= 32'd1000000;
         press_ff      <= 32'd200000;
         release_ff    <= 32'd200000;
         retry_ff      <= 32'd10000000;
         idle_ff       <= 32'd60000000;
         fail_min_ff   <= 32'd0;
         fail_max_ff   <= 32'd0;
      end else if (csr_write) begin
         unique case (csr_paddr[4:2])
            REG_POWER_WAIT: power_wait_ff <= csr_pwdata;
            REG_PRESS:      press_ff      <= csr_pwdata;
            REG_RELEASE:    release_ff    <= csr_pwdata;
            REG_RETRY:      retry_ff      <= csr_pwdata;
            REG_IDLE:       idle_ff       <= csr_pwdata;
            REG_FAIL_MIN:   fail_min_ff   <= csr_pwdata;
            REG_FAIL_MAX:   fail_max_ff   <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[4:2])
         REG_POWER_WAIT: csr_prdata = power_wait_ff;
         REG_PRESS:      csr_prdata = press_ff;
         REG_RELEASE:    csr_prdata = release_ff;
         REG_RETRY:      csr_prdata = retry_ff;
         REG_IDLE:       csr_prdata = idle_ff;
         REG_FAIL_MIN:   csr_prdata = fail_min_ff;
         REG_FAIL_MAX:   csr_prdata = fail_max_ff;
         default:        csr_prdata = 32'd0;
      endcase
   end

   // handshakes
   assign req_tready = (count_ff != 2'd2);
   assign req_accept = req_tvalid & req_tready;
   assign rsp_tvalid = (count_ff != 2'd0);
   assign rsp_accept = rsp_tvalid & rsp_tready;
   assign req_line   = req_tdata[0];

   // next state: command, then tick count, timer expiry, line change
   always_comb begin
      logic [CmpBits-1:0] dur;
      logic               win;
      phase_in      = phase_ff;
      countdown_in  = countdown_ff;
      running_in    = running_ff;
      armed_in      = armed_ff;
      last_level_in = last_level_ff;
      requested_in  = requested_ff;
      since_in      = since_ff;
      event_in      = EV_NONE;
      dur           = '0;
      win           = 1'b0;
      if (req_accept) begin
         if (req_tuser == CMD_POWER_ON) begin
            if (phase_ff == PH_POWER_OFF) begin
               phase_in     = PH_POWER_ON_WAIT;
               countdown_in = power_wait_ff;
               running_in   = 1'b1;
            end
         end else begin
            // saturating time since last line change
            if (since_ff != SinceMax) since_in = since_ff + TICK_COUNTER_BITS'(1);
            // countdown and expiry action
            if (running_ff) begin
               if (countdown_ff <= 32'd1) begin
                  running_in   = 1'b0;
                  countdown_in = 32'd0;
                  unique case (phase_ff)
                     PH_POWER_OFF, PH_POWER_ON_WAIT: begin
                        phase_in = PH_POWER_ON;
                        armed_in = 1'b1;
                     end
                     PH_PRESS_RC_OFF: begin
                        phase_in     = PH_RELEASE_RC_OFF;
                        countdown_in = release_ff;
                        running_in   = 1'b1;
                     end
                     PH_RELEASE_RC_OFF: begin
                        phase_in = PH_RC_OFF;
                        if (!requested_ff) begin
                           phase_in     = PH_PRESS_FORMAT;
                           countdown_in = press_ff;
                           running_in   = 1'b1;
                        end
                     end
                     PH_PRESS_FORMAT: begin
                        phase_in     = PH_RELEASE_FORMAT;
                        countdown_in = release_ff;
                        running_in   = 1'b1;
                     end
                     PH_RUNNING: begin
                        event_in     = EV_STOPPED;
                        phase_in     = PH_PRESS_RC_ON;
                        countdown_in = press_ff;
                        running_in   = 1'b1;
                     end
                     PH_RELEASE_FORMAT, PH_RC_ON: begin
                        phase_in     = PH_PRESS_RC_ON;
                        countdown_in = press_ff;
                        running_in   = 1'b1;
                     end
                     PH_PRESS_RC_ON: begin
                        phase_in     = PH_RELEASE_RC_ON;
                        countdown_in = release_ff;
                        running_in   = 1'b1;
                     end
                     PH_RELEASE_RC_ON: begin
                        if (requested_ff) begin
                           phase_in = PH_RUNNING;
                           event_in = EV_READY;
                        end else begin
                           phase_in     = PH_RC_ON;
                           countdown_in = retry_ff;
                           running_in   = 1'b1;
                        end
                     end
                     default: ;
                  endcase
               end else begin
                  countdown_in = countdown_ff - 32'd1;
               end
            end
            // request line change, seen after the expiry of this tick
            if (armed_in && (req_line != last_level_ff)) begin
               dur           = CmpBits'(since_in);
               win           = (dur >= CmpBits'(fail_min_ff)) &&
                               (dur <= CmpBits'(fail_max_ff));
               since_in      = '0;
               last_level_in = req_line;
               requested_in  = ~req_line;
               if (!req_line) begin
                  if (phase_in == PH_POWER_ON) begin
                     phase_in     = PH_PRESS_RC_OFF;
                     countdown_in = press_ff;
                     running_in   = 1'b1;
                  end else if (phase_in == PH_RC_ON) begin
                     phase_in     = PH_RUNNING;
                     countdown_in = 32'd0;
                     running_in   = 1'b0;
                     event_in     = EV_READY;
                  end else if (phase_in == PH_RUNNING) begin
                     countdown_in = 32'd0;
                     running_in   = 1'b0;
                  end
               end else begin
                  if (phase_in == PH_RC_OFF) begin
                     phase_in     = PH_PRESS_FORMAT;
                     countdown_in = press_ff;
                     running_in   = 1'b1;
                  end else if (phase_in == PH_RUNNING) begin
                     running_in = 1'b1;
                     if (win) begin
                        phase_in     = PH_RC_ON;
                        countdown_in = retry_ff;
                        event_in     = EV_RECOVER;
                     end else begin
                        countdown_in = idle_ff;
                     end
                  end
               end
            end
         end
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_POWER_OFF;
         countdown_ff  <= 32'd0;
         running_ff    <= 1'b0;
         armed_ff      <= 1'b0;
         last_level_ff <= 1'b1;
         requested_ff  <= 1'b0;
         since_ff      <= SinceMax;
      end else begin
         phase_ff      <= phase_in;
         countdown_ff  <= countdown_in;
         running_ff    <= running_in;
         armed_ff      <= armed_in;
         last_level_ff <= last_level_in;
         requested_ff  <= requested_in;
         since_ff      <= since_in;
      end
   end

   // result word from the state after this transaction
   assign result_word = {event_in, requested_in, phase_in,
                         (phase_in == PH_PRESS_FORMAT),
                         (phase_in == PH_PRESS_RC_OFF) || (phase_in == PH_PRESS_RC_ON),
                         (phase_in == PH_POWER_OFF)};

   // two-entry result queue
   always_ff @(posedge clock) begin
      if (req_accept) queue_ff[wr_ptr_ff] <= result_word;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (req_accept) wr_ptr_ff <= ~wr_ptr_ff;
         if (rsp_accept) rd_ptr_ff <= ~rd_ptr_ff;
         case ({req_accept, rsp_accept})
            2'b10:   count_ff <= count_ff + 2'd1;
            2'b01:   count_ff <= count_ff - 2'd1;
            default: count_ff <= count_ff;
         endcase
      end
   end

   assign rsp_tdata = {{(RSP_TDATA_BITS-RESULT_BITS){1'b0}}, queue_ff[rd_ptr_ff]};

endmodule

/* hw/rtl/rcbs_checker.sv */
// Port-level checker for the radio clock button sequencer, and its bind.
// Depends on rcbs_pkg; binds to radio_clock_button_sequencer_unit.
module rcbs_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [rcbs_pkg::RSP_TDATA_BITS-1:0] rsp_tdata,
   input logic                                csr_pready
);
   import rcbs_pkg::*;

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // power drive bit is set exactly in the power-off phase
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[0] == (rsp_tdata[6:3] == PH_POWER_OFF)))
      else $error("power drive disagrees with phase");

   // ready is only reported on entry to running
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[9:8] == EV_READY) |-> (rsp_tdata[6:3] == PH_RUNNING))
      else $error("ready event outside running phase");

   // recovery always lands in radio-control-on with no button held
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[9:8] == EV_RECOVER) |->
         (rsp_tdata[6:3] == PH_RC_ON) && !rsp_tdata[1] && !rsp_tdata[2])
      else $error("recovery event in wrong phase");

   // register port never waits
   assert property (@(posedge clock) csr_pready)
      else $error("pready low");

endmodule

bind radio_clock_button_sequencer_unit rcbs_checker u_rcbs_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .csr_pready (csr_pready)
);

/* dv/tb.sv */
// Self-checking bench for the radio clock button sequencer top level.
// Drives tick and power-on transactions plus APB register writes and checks every result
// against a typed-in expectation or a cycle-free model of the phase machine. Depends on rcbs_pkg.
`timescale 1ns / 100ps

module tb;
   import rcbs_pkg::*;

   localparam int unsigned TICK_BITS = 32;

   // Directed script row kinds and register setting styles
   typedef enum logic {ROW_ITEM, ROW_CSR} row_kind_type;
   typedef enum logic [1:0] {
      SET_SMALL, SET_WIDE_WINDOW, SET_NO_WINDOW, SET_CEILING
   } setting_type;

   // Result word, highest field first so the packing matches rsp_tdata[9:0]
   typedef struct packed {
      event_type ev;
      logic      sig;
      phase_type ph;
      logic      fmt;
      logic      radio;
      logic      pwr;
   } seq_result_type;

   // Optional typed-in expectation travelling with each transaction
   typedef struct packed {
      logic           given;
      seq_result_type val;
   } exp_note_type;

   typedef struct {
      row_kind_type   kind;
      logic           cmd;
      logic           lvl;
      reg_type        r;
      logic [31:0]    val;
      logic           given;
      seq_result_type want;
   } script_row_type;

   localparam seq_result_type RES_OFF =
      '{ev: EV_NONE, sig: 1'b0, ph: PH_POWER_OFF, fmt: 1'b0, radio: 1'b0, pwr: 1'b1};
   localparam seq_result_type RES_WAIT =
      '{ev: EV_NONE, sig: 1'b0, ph: PH_POWER_ON_WAIT, fmt: 1'b0, radio: 1'b0, pwr: 1'b0};
   localparam seq_result_type RES_NIL = '0;

   // DUT connections
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic        req_tuser = CMD_TICK;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [RSP_TDATA_BITS-1:0] rsp_tdata;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   radio_clock_button_sequencer_unit #(
      .TICK_COUNTER_BITS(TICK_BITS)
   ) i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),   // [0] request_line
      .req_tuser   (req_tuser),   // [0] command
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),   // [0] power, [1] radio btn, [2] format btn, [6:3] phase,
                                  // [7] signal requested, [9:8] event
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #1 clock = ~clock;

   // Hard stop in case the handshakes hang
   initial begin
      #400000;
      $display("status: fail");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Model state and register copy
   // ---------------------------------------------------------------------
   logic [31:0]          cfg [0:6];
   phase_type            ph;
   event_type            ev;
   logic [31:0]          cnt;
   logic                 cnt_run;
   logic                 armed;
   logic                 last_lvl;
   logic                 req_flag;
   logic [TICK_BITS-1:0] since;

   seq_result_type results_due [$];
   exp_note_type   notes_sent [$];
   int          fail_count = 0;
   int          tx_idle_pct = 0;
   int          rx_idle_pct = 0;
   logic        level = 1'b1;
   int          hold = 0;

   task automatic report(input string msg);
      $display("ERROR %0t: %s", $time, msg);
      fail_count++;
   endtask

   function automatic void seq_reset();
      cfg[REG_POWER_WAIT] = 32'd1000000;
      cfg[REG_PRESS]      = 32'd200000;
      cfg[REG_RELEASE]    = 32'd200000;
      cfg[REG_RETRY]      = 32'd10000000;
      cfg[REG_IDLE]       = 32'd60000000;
      cfg[REG_FAIL_MIN]   = 32'd0;
      cfg[REG_FAIL_MAX]   = 32'd0;
      ph       = PH_POWER_OFF;
      ev       = EV_NONE;
      cnt      = '0;
      cnt_run  = 1'b0;
      armed    = 1'b0;
      last_lvl = 1'b1;
      req_flag = 1'b0;
      since    = '1;
   endfunction

   function automatic void timer_load(input logic [31:0] ticks);
      cnt     = ticks;
      cnt_run = 1'b1;
   endfunction

   function automatic void timer_stop();
      cnt_run = 1'b0;
      cnt     = '0;
   endfunction

   function automatic void start_press(input phase_type p);
      ph = p;
      timer_load(cfg[REG_PRESS]);
   endfunction

   function automatic void enter_running();
      ph = PH_RUNNING;
      timer_stop();
      ev = EV_READY;
   endfunction

   // Request line edge: duration is the tick count since the previous edge
   function automatic void line_change(input logic lvl);
      logic [TICK_BITS-1:0] dur;
      if (!armed || lvl == last_lvl) return;
      dur      = since;
      since    = '0;
      last_lvl = lvl;
      req_flag = (lvl == 1'b0);
      if (req_flag) begin
         if (ph == PH_POWER_ON) start_press(PH_PRESS_RC_OFF);
         else if (ph == PH_RC_ON) enter_running();
         else if (ph == PH_RUNNING) timer_stop();
      end else begin
         if (ph == PH_RC_OFF) start_press(PH_PRESS_FORMAT);
         if (ph == PH_RUNNING) begin
            if (dur >= cfg[REG_FAIL_MIN] && dur <= cfg[REG_FAIL_MAX]) begin
               ph = PH_RC_ON;
               timer_load(cfg[REG_RETRY]);
               ev = EV_RECOVER;
            end else begin
               timer_load(cfg[REG_IDLE]);
            end
         end
      end
   endfunction

   // Countdown expiry: per-phase action
   function automatic void timer_expire(input logic lvl);
      case (ph)
         PH_POWER_OFF, PH_POWER_ON_WAIT: begin
            ph    = PH_POWER_ON;
            armed = 1'b1;
            line_change(lvl);
         end
         PH_PRESS_RC_OFF: begin
            ph = PH_RELEASE_RC_OFF;
            timer_load(cfg[REG_RELEASE]);
         end
         PH_RELEASE_RC_OFF: begin
            ph = PH_RC_OFF;
            if (!req_flag) start_press(PH_PRESS_FORMAT);
         end
         PH_PRESS_FORMAT: begin
            ph = PH_RELEASE_FORMAT;
            timer_load(cfg[REG_RELEASE]);
         end
         PH_RUNNING: begin
            ev = EV_STOPPED;
            start_press(PH_PRESS_RC_ON);
         end
         PH_RELEASE_FORMAT, PH_RC_ON: start_press(PH_PRESS_RC_ON);
         PH_PRESS_RC_ON: begin
            ph = PH_RELEASE_RC_ON;
            timer_load(cfg[REG_RELEASE]);
         end
         PH_RELEASE_RC_ON: begin
            ph = PH_RC_ON;
            if (req_flag) enter_running();
            else timer_load(cfg[REG_RETRY]);
         end
         default: ;
      endcase
   endfunction

   // One transaction through the model; returns the result it causes
   function automatic seq_result_type advance_sequencer(input logic cmd, input logic lvl);
      seq_result_type r;
      ev = EV_NONE;
      if (cmd == CMD_POWER_ON) begin
         if (ph == PH_POWER_OFF) begin
            ph = PH_POWER_ON_WAIT;
            timer_load(cfg[REG_POWER_WAIT]);
         end
      end else begin
         if (since != '1) since++;
         if (cnt_run) begin
            if (cnt <= 32'd1) begin
               timer_stop();
               timer_expire(lvl);
            end else begin
               cnt--;
            end
         end
         line_change(lvl);
      end
      r.pwr   = (ph == PH_POWER_OFF);
      r.radio = (ph == PH_PRESS_RC_OFF || ph == PH_PRESS_RC_ON);
      r.fmt   = (ph == PH_PRESS_FORMAT);
      r.ph    = ph;
      r.sig   = req_flag;
      r.ev    = ev;
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Monitor: score results, then predict newly accepted transactions
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      seq_result_type got, want, pred;
      exp_note_type   note;
      if (reset) begin
         seq_reset();
         results_due.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = seq_result_type'(rsp_tdata[9:0]);
            if (results_due.size() == 0) begin
               report($sformatf("result 0x%0h with nothing expected", rsp_tdata));
            end else begin
               want = results_due.pop_front();
               if (got.pwr !== want.pwr)
                  report($sformatf("power_drive %0b, expected %0b", got.pwr, want.pwr));
               if (got.radio !== want.radio)
                  report($sformatf("radio press %0b, expected %0b", got.radio, want.radio));
               if (got.fmt !== want.fmt)
                  report($sformatf("format press %0b, expected %0b", got.fmt, want.fmt));
               if (got.ph !== want.ph)
                  report($sformatf("phase %0d, expected %0d", got.ph, want.ph));
               if (got.sig !== want.sig)
                  report($sformatf("signal requested %0b, expected %0b", got.sig, want.sig));
               if (got.ev !== want.ev)
                  report($sformatf("event %0d, expected %0d", got.ev, want.ev));
               if (rsp_tdata[RSP_TDATA_BITS-1:10] !== '0)
                  report($sformatf("padding bits set in 0x%0h", rsp_tdata));
            end
         end
         if (req_tvalid && req_tready) begin
            note = notes_sent.pop_front();
            pred = advance_sequencer(req_tuser, req_tdata[0]);
            results_due.push_back(note.given ? note.val : pred);
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             csr_paddr[4:2] <= REG_FAIL_MAX)
            cfg[csr_paddr[4:2]] = csr_pwdata;
      end
   end

   // Result side back-pressure
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
   end

   // ---------------------------------------------------------------------
   // Drivers
   // ---------------------------------------------------------------------
   task automatic send_item(input logic cmd, input logic lvl, input exp_note_type note);
      @(negedge clock);
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      notes_sent.push_back(note);
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {7'd0, lvl};
      do @(posedge clock); while (!req_tready);
   endtask

   // Hold the input side until every expected result has been taken
   task automatic wait_drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (results_due.size() != 0) @(negedge clock);
   endtask

   task automatic csr_write(input reg_type r, input logic [31:0] v);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {r, 2'b00};
      csr_pwdata  <= v;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic apply_setting(input setting_type mode);
      logic [31:0] v [0:6];
      for (int i = 0; i <= REG_IDLE; i++) begin
         case (mode)
            SET_CEILING:   v[i] = '1;
            SET_NO_WINDOW: v[i] = 32'd1;
            default:       v[i] = $urandom_range(1, 4);
         endcase
      end
      case (mode)
         SET_SMALL: begin
            v[REG_FAIL_MIN] = $urandom_range(0, 3);
            v[REG_FAIL_MAX] = v[REG_FAIL_MIN] + $urandom_range(0, 4);
         end
         SET_NO_WINDOW: begin
            v[REG_FAIL_MIN] = '0;
            v[REG_FAIL_MAX] = '0;
         end
         default: begin
            v[REG_FAIL_MIN] = '0;
            v[REG_FAIL_MAX] = '1;
         end
      endcase
      wait_drain();
      for (int i = 0; i <= REG_FAIL_MAX; i++) csr_write(reg_type'(i), v[i]);
   endtask

   // Mostly clean line pulses of random length, with glitches, stray power-on
   // requests and the odd full drain mixed in
   task automatic run_segment(input int n_ticks);
      int done;
      int roll;
      done = 0;
      while (done < n_ticks) begin
         roll = $urandom_range(0, 99);
         if (roll < 4) begin
            send_item(CMD_POWER_ON, 1'($urandom_range(0, 1)), '0);
         end else if (roll < 5) begin
            wait_drain();
         end else begin
            if (hold == 0) begin
               level = ~level;
               hold  = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24)
                                                    : $urandom_range(1, 6);
            end
            if ($urandom_range(0, 19) == 0) send_item(CMD_TICK, ~level, '0);
            else send_item(CMD_TICK, level, '0);
            hold--;
            done++;
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // Directed script: power-off behaviour at reset defaults, then a full
   // walk through every phase with short timers
   // ---------------------------------------------------------------------
   script_row_type script [0:32] = '{
      '{ROW_ITEM, CMD_TICK,     1'b1, REG_POWER_WAIT, 32'd0, 1'b1, RES_OFF},
      '{ROW_ITEM, CMD_TICK,     1'b0, REG_POWER_WAIT, 32'd0, 1'b1, RES_OFF},
      '{ROW_CSR,  CMD_TICK,     1'b1, REG_POWER_WAIT, 32'd2, 1'b0, RES_NIL},
      '{ROW_CSR,  CMD_TICK,     1'b1, REG_PRESS,      32'd1, 1'b0, RES_NIL},
      '{ROW_CSR,  CMD_TICK,     1'b1, REG_RELEASE,    32'd1, 1'b0, RES_NIL},
      '{ROW_CSR,  CMD_TICK,     1'b1, REG_RETRY,      32'd3, 1'b0, RES_NIL},
      '{ROW_CSR,  CMD_TICK,     1'b1, REG_IDLE,       32'd2, 1'b0, RES_NIL},
      '{ROW_CSR,  CMD_TICK,     1'b1, REG_FAIL_MIN,   32'd1, 1'b0, RES_NIL},
      '{ROW_CSR,  CMD_TICK,     1'b1, REG_FAIL_MAX,   32'd2, 1'b0, RES_NIL},
      '{ROW_ITEM, CMD_POWER_ON, 1'b0, REG_POWER_WAIT, 32'd0, 1'b1, RES_WAIT},
      // repeated power-on is ignored once out of power off
      '{ROW_ITEM, CMD_POWER_ON, 1'b1, REG_POWER_WAIT, 32'd0, 1'b1, RES_WAIT},
      '{ROW_ITEM, CMD_TICK,     1'b1, REG_POWER_WAIT, 32'd0, 1'b0, RES_NIL},
      // line armed and sampled low in the same tick
      '{ROW_ITEM, CMD_TICK,     1'b0, REG_POWER_WAIT, 32'd0, 1'b0, RES_NIL},
      '{ROW_ITEM, CMD_TICK,     1'b0, REG_POWER_WAIT, 32'd0, 1'b0, RES_NIL},
      '{ROW_ITEM, CMD_POWER_ON, 1'b0, REG_POWER_WAIT, 32'd0, 1'b0, RES_NIL},
      '{ROW_ITEM, CMD_TICK,     1'b0, REG_POWER_WAIT, 32'd0, 1'b0, RES_NIL},
      '{ROW_ITEM, CMD_TICK,     1'b1, REG_POWER_WAIT, 32'd0, 1'b0, RES_NIL},
      '{ROW_ITEM, CMD_TICK,     1'b1, REG_POWER_WAIT, 32'd0, 1'b0, RES_NIL},
      '{ROW_ITEM, CMD_TICK,     1'b1, REG_POWER_WAIT, 32'd0, 1'b0, RES_NIL},
      '{ROW_ITEM, CMD_TICK,     1'b1, REG_POWER_WAIT, 32'd0, 1'b0, RES_NIL},
      '{ROW_ITEM, CMD_TICK,     1'b1, REG_POWER_WAIT, 32'd0, 1'b0, RES_NIL},
      // request while waiting to retry: ready
      '{ROW_ITEM, CMD_TICK,     1'b0, REG_POWER_WAIT, 32'd0, 1'b0, RES_NIL},
      // short request inside the failure window: recovery
      '{ROW_ITEM, CMD_TICK,     1'b1, REG_POWER_WAIT, 32'd0, 1'b0, RES_NIL},
      '{ROW_ITEM, CMD_TICK,     1'b1, REG_POWER_WAIT, 32'd0, 1'b0, RES_NIL},
      '{ROW_ITEM, CMD_TICK,     1'b1, REG_POWER_WAIT, 32'd0, 1'b0, RES_NIL},
      '{ROW_ITEM, CMD_TICK,     1'b1, REG_POWER_WAIT, 32'd0, 1'b0, RES_NIL},
      '{ROW_ITEM, CMD_TICK,     1'b1, REG_POWER_WAIT, 32'd0, 1'b0, RES_NIL},
      // expiry and line change in one tick, the change wins
      '{ROW_ITEM, CMD_TICK,     1'b0, REG_POWER_WAIT, 32'd0, 1'b0, RES_NIL},
      '{ROW_ITEM, CMD_TICK,     1'b0, REG_POWER_WAIT, 32'd0, 1'b0, RES_NIL},
      '{ROW_ITEM, CMD_TICK,     1'b0, REG_POWER_WAIT, 32'd0, 1'b0, RES_NIL},
      // long request outside the window: idle timeout, then stopped
      '{ROW_ITEM, CMD_TICK,     1'b1, REG_POWER_WAIT, 32'd0, 1'b0, RES_NIL},
      '{ROW_ITEM, CMD_TICK,     1'b1, REG_POWER_WAIT, 32'd0, 1'b0, RES_NIL},
      '{ROW_ITEM, CMD_TICK,     1'b1, REG_POWER_WAIT, 32'd0, 1'b0, RES_NIL}
   };

   setting_type seg_mode [0:5] = '{SET_SMALL, SET_WIDE_WINDOW, SET_SMALL,
                                   SET_NO_WINDOW, SET_SMALL, SET_CEILING};

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      tx_idle_pct = 14;
      rx_idle_pct = 52;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (script[i]) begin
         if (script[i].kind == ROW_CSR) begin
            wait_drain();
            csr_write(script[i].r, script[i].val);
         end else begin
            send_item(script[i].cmd, script[i].lvl, '{script[i].given, script[i].want});
         end
      end

      // Random part: sender/receiver idling swapped after two segments, then none for the last two
      level = 1'b1;
      hold  = 0;
      for (int seg = 0; seg < 6; seg++) begin
         case (seg / 2)
            0: begin tx_idle_pct = 14; rx_idle_pct = 52; end
            1: begin tx_idle_pct = 52; rx_idle_pct = 14; end
            default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
         endcase
         apply_setting(seg_mode[seg]);
         run_segment(125);
      end

      wait_drain();
      repeat (8) @(posedge clock);
      if (fail_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
